>>> rtl/core/ufrx_pkg.sv
// Shared types, codes and register reset values of the frame receiver.
`default_nettype none
package ufrx_pkg;

    // Frame format
    localparam logic [7:0] START_BYTE = 8'h55;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_LENGTH      = 4'd0,
        REG_HEADER_TIMEOUT  = 4'd1,
        REG_PAYLOAD_TIMEOUT = 4'd2,
        REG_CHECK_TIMEOUT   = 4'd3
    } cfg_reg_t;

    localparam logic [15:0] MAX_LENGTH_RST      = 16'd1024;
    localparam logic [15:0] HEADER_TIMEOUT_RST  = 16'd200;
    localparam logic [15:0] PAYLOAD_TIMEOUT_RST = 16'd500;
    localparam logic [15:0] CHECK_TIMEOUT_RST   = 16'd50;

    // Input item operations
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    // Reject causes
    typedef enum logic [1:0] {
        CAUSE_MISMATCH = 2'd0,
        CAUSE_TOO_LONG = 2'd1,
        CAUSE_PAYLOAD  = 2'd2,
        CAUSE_CHECK    = 2'd3
    } cause_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [7:0]  command;
        logic [15:0] frame_length;
        logic [1:0]  reject_cause;
    } out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/ufrx_if.sv
// Valid/ready channel interfaces for the input and result items.
`default_nettype none
interface ufrx_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface ufrx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  command;
    logic [15:0] frame_length;
    logic [1:0]  reject_cause;

    modport source (output valid, output kind, output data, output command,
                    output frame_length, output reject_cause, input ready);
    modport sink   (input valid, input kind, input data, input command,
                    input frame_length, input reject_cause, output ready);
endinterface
`default_nettype wire

>>> rtl/core/uart_frame_receiver_xor_top.sv
// Frame receiver: start byte, length, command, payload and XOR check byte.
// A result item is registered and shown in the cycle after its item is taken.
// Throughput: one item per cycle; the frame state is updated in the accepting
// cycle and the result lands in a single output register.
// An item is taken whenever the output register is empty or being drained.
// Reset (rst_n low, asynchronous) returns to hunting for the start byte and
// restores the register defaults (1024, 200, 500, 50).
`default_nettype none
module uart_frame_receiver_xor_top
    import ufrx_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    ufrx_in_if.sink                     din,
    ufrx_out_if.source                  dout
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_CMD     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    // Configuration registers
    logic [15:0] max_length_reg;
    logic [15:0] header_timeout_reg;
    logic [15:0] payload_timeout_reg;
    logic [15:0] check_timeout_reg;

    // Frame state
    phase_t      phase_reg,    phase_next;
    logic [15:0] length_reg,   length_next;
    logic [15:0] count_reg,    count_next;
    logic [7:0]  command_reg,  command_next;
    logic [7:0]  xor_reg,      xor_next;
    logic [15:0] tick_reg,     tick_next;
    logic        oversize_reg, oversize_next;

    // Output register
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        emit;
    out_item_t   result;

    logic        accept;
    logic [16:0] tick_inc;
    logic [15:0] tick_sat;
    logic [15:0] limit;
    logic        expired;
    logic [15:0] count_inc;

    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    // Saturating tick count and expiry against the current phase's limit.
    always_comb
    begin
        tick_inc = {1'b0, tick_reg} + 17'd1;
        tick_sat = tick_inc[16] ? 16'hFFFF : tick_inc[15:0];
        case (phase_reg)
            PH_PAYLOAD: limit = payload_timeout_reg;
            PH_CHECK:   limit = check_timeout_reg;
            default:    limit = header_timeout_reg;
        endcase
        expired   = tick_sat >= limit;
        count_inc = count_reg + 16'd1;
    end

    // Next frame state and the result item for one input item.
    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        command_next  = command_reg;
        xor_next      = xor_reg;
        tick_next     = tick_reg;
        oversize_next = oversize_reg;
        emit          = 1'b0;
        result.kind         = KIND_DATA;
        result.data         = 8'd0;
        result.command      = command_reg;
        result.frame_length = length_reg;
        result.reject_cause = CAUSE_MISMATCH;

        if (din.op == OP_TICK)
        begin
            case (phase_reg)
                PH_LEN_LO, PH_LEN_HI, PH_CMD:
                begin
                    tick_next = tick_sat;
                    if (expired)
                    begin
                        phase_next = PH_HUNT;
                        tick_next  = 16'd0;
                    end
                end
                PH_PAYLOAD:
                begin
                    tick_next = tick_sat;
                    if (expired)
                    begin
                        phase_next          = PH_HUNT;
                        tick_next           = 16'd0;
                        emit                = 1'b1;
                        result.kind         = KIND_REJECT;
                        result.reject_cause = CAUSE_PAYLOAD;
                    end
                end
                PH_CHECK:
                begin
                    tick_next = tick_sat;
                    if (expired)
                    begin
                        phase_next          = PH_HUNT;
                        tick_next           = 16'd0;
                        emit                = 1'b1;
                        result.kind         = KIND_REJECT;
                        result.reject_cause = oversize_reg ? CAUSE_TOO_LONG : CAUSE_CHECK;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                // The timer keeps running over both length bytes.
                PH_LEN_LO:
                begin
                    length_next = {8'd0, din.rx_byte};
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next = {din.rx_byte, length_reg[7:0]};
                    phase_next  = PH_CMD;
                    tick_next   = 16'd0;
                end
                PH_CMD:
                begin
                    command_next  = din.rx_byte;
                    xor_next      = din.rx_byte;
                    count_next    = 16'd0;
                    tick_next     = 16'd0;
                    oversize_next = length_reg > max_length_reg;
                    if (length_reg > max_length_reg || length_reg == 16'd0)
                        phase_next = PH_CHECK;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    xor_next    = xor_reg ^ din.rx_byte;
                    count_next  = count_inc;
                    emit        = 1'b1;
                    result.data = din.rx_byte;
                    if (count_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                        tick_next  = 16'd0;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                    tick_next  = 16'd0;
                    emit       = 1'b1;
                    if (oversize_reg)
                    begin
                        result.kind         = KIND_REJECT;
                        result.reject_cause = CAUSE_TOO_LONG;
                    end
                    else if (din.rx_byte != xor_reg)
                    begin
                        result.kind         = KIND_REJECT;
                        result.reject_cause = CAUSE_MISMATCH;
                    end
                    else
                    begin
                        result.kind = KIND_ACCEPT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (din.rx_byte == START_BYTE)
                    begin
                        phase_next = PH_LEN_LO;
                        tick_next  = 16'd0;
                    end
                end
            endcase
        end
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg      <= MAX_LENGTH_RST;
            header_timeout_reg  <= HEADER_TIMEOUT_RST;
            payload_timeout_reg <= PAYLOAD_TIMEOUT_RST;
            check_timeout_reg   <= CHECK_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MAX_LENGTH:      max_length_reg      <= wr_data;
                REG_HEADER_TIMEOUT:  header_timeout_reg  <= wr_data;
                REG_PAYLOAD_TIMEOUT: payload_timeout_reg <= wr_data;
                REG_CHECK_TIMEOUT:   check_timeout_reg   <= wr_data;
                default: ;
            endcase
        end
    end

    // Frame state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            length_reg    <= 16'd0;
            count_reg     <= 16'd0;
            command_reg   <= 8'd0;
            xor_reg       <= 8'd0;
            tick_reg      <= 16'd0;
            oversize_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                length_reg   <= length_next;
                count_reg    <= count_next;
                command_reg  <= command_next;
                xor_reg      <= xor_next;
                tick_reg     <= tick_next;
                oversize_reg <= oversize_next;
            end
            if (accept)
                out_valid_reg <= emit;
            else if (dout.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_item_reg <= result;
    end

    assign dout.valid        = out_valid_reg;
    assign dout.kind         = out_item_reg.kind;
    assign dout.data         = out_item_reg.data;
    assign dout.command      = out_item_reg.command;
    assign dout.frame_length = out_item_reg.frame_length;
    assign dout.reject_cause = out_item_reg.reject_cause;

endmodule
`default_nettype wire

>>> bench/uart_frame_receiver_xor_top_tb.sv
// Self-checking testbench of the frame receiver with XOR check and tick timeouts.
module uart_frame_receiver_xor_top_tb;
    import ufrx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 9;
    localparam int PHASE_ITEMS    = 320;
    localparam int TICK_CAP       = 250;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    // Receiver phases, as the block walks through one frame.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CMD,
        PH_PAYLOAD,
        PH_CHECK
    } rx_phase_t;

    // What a randomly planned frame is meant to exercise.
    typedef enum int {
        PLAN_GOOD,
        PLAN_BAD_CHECK,
        PLAN_OVERSIZE,
        PLAN_PAYLOAD_STALL,
        PLAN_CHECK_STALL,
        PLAN_HEADER_STALL,
        PLAN_TRUNCATED
    } frame_plan_t;

    // Tracks the frame state from accepted items and holds the results due.
    class frame_scoreboard;
        logic [15:0] max_len;
        logic [15:0] hdr_limit;
        logic [15:0] pay_limit;
        logic [15:0] chk_limit;
        rx_phase_t   rx_state;
        logic [15:0] frame_len;
        logic [15:0] byte_count;
        logic [15:0] tick_count;
        logic [7:0]  cmd_byte;
        logic [7:0]  xor_acc;
        bit          oversize;
        out_item_t   due_results[$];
        int          mismatches;

        function new();
            max_len    = MAX_LENGTH_RST;
            hdr_limit  = HEADER_TIMEOUT_RST;
            pay_limit  = PAYLOAD_TIMEOUT_RST;
            chk_limit  = CHECK_TIMEOUT_RST;
            rx_state   = PH_HUNT;
            frame_len  = '0;
            byte_count = '0;
            tick_count = '0;
            cmd_byte   = '0;
            xor_acc    = '0;
            oversize   = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [15:0] value);
            case (idx)
                REG_MAX_LENGTH:      max_len = value;
                REG_HEADER_TIMEOUT:  hdr_limit = value;
                REG_PAYLOAD_TIMEOUT: pay_limit = value;
                REG_CHECK_TIMEOUT:   chk_limit = value;
                default: ;
            endcase
        endfunction

        function void enter_phase(rx_phase_t next_state);
            rx_state   = next_state;
            tick_count = '0;
        endfunction

        // Counts one tick, saturating; a limit of zero expires like one.
        function bit timer_expired(logic [15:0] limit);
            if (tick_count != 16'hFFFF)
                tick_count++;
            return tick_count >= limit;
        endfunction

        function void add_due(kind_t kind, logic [7:0] data, cause_t cause);
            out_item_t res;
            res.kind         = kind;
            res.data         = data;
            res.command      = cmd_byte;
            res.frame_length = frame_len;
            res.reject_cause = cause;
            due_results.push_back(res);
        endfunction

        // Advances the frame state by one accepted item.
        function void track_rx_item(in_item_t it);
            logic [7:0] b;
            b = it.rx_byte;
            if (it.op == OP_TICK)
            begin
                case (rx_state)
                    PH_LEN_LO, PH_LEN_HI, PH_CMD:
                    begin
                        if (timer_expired(hdr_limit))
                            enter_phase(PH_HUNT);
                    end
                    PH_PAYLOAD:
                    begin
                        if (timer_expired(pay_limit))
                        begin
                            enter_phase(PH_HUNT);
                            add_due(KIND_REJECT, 8'h00, CAUSE_PAYLOAD);
                        end
                    end
                    PH_CHECK:
                    begin
                        if (timer_expired(chk_limit))
                        begin
                            enter_phase(PH_HUNT);
                            if (oversize)
                                add_due(KIND_REJECT, 8'h00, CAUSE_TOO_LONG);
                            else
                                add_due(KIND_REJECT, 8'h00, CAUSE_CHECK);
                        end
                    end
                    default: rx_state = PH_HUNT;
                endcase
            end
            else
            begin
                case (rx_state)
                    PH_LEN_LO:
                    begin
                        // The header timer keeps running over both length bytes.
                        frame_len = {8'h00, b};
                        rx_state  = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        frame_len[15:8] = b;
                        enter_phase(PH_CMD);
                    end
                    PH_CMD:
                    begin
                        cmd_byte   = b;
                        xor_acc    = b;
                        byte_count = '0;
                        if (frame_len > max_len)
                        begin
                            oversize = 1'b1;
                            enter_phase(PH_CHECK);
                        end
                        else
                        begin
                            oversize = 1'b0;
                            if (frame_len == 0)
                                enter_phase(PH_CHECK);
                            else
                                enter_phase(PH_PAYLOAD);
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        xor_acc ^= b;
                        byte_count++;
                        if (byte_count >= frame_len)
                            enter_phase(PH_CHECK);
                        add_due(KIND_DATA, b, CAUSE_MISMATCH);
                    end
                    PH_CHECK:
                    begin
                        enter_phase(PH_HUNT);
                        if (oversize)
                            add_due(KIND_REJECT, 8'h00, CAUSE_TOO_LONG);
                        else if (b != xor_acc)
                            add_due(KIND_REJECT, 8'h00, CAUSE_MISMATCH);
                        else
                            add_due(KIND_ACCEPT, 8'h00, CAUSE_MISMATCH);
                    end
                    default:
                    begin
                        rx_state = PH_HUNT;
                        if (b == START_BYTE)
                            enter_phase(PH_LEN_LO);
                    end
                endcase
            end
        endfunction

        function void report_failure(string what, out_item_t want, out_item_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t %s: expected kind=%0d data=%02h cmd=%02h len=%0d cause=%0d,",
                         $realtime, what, want.kind, want.data, want.command,
                         want.frame_length, want.reject_cause);
                $display("    got kind=%0d data=%02h cmd=%02h len=%0d cause=%0d",
                         got.kind, got.data, got.command, got.frame_length,
                         got.reject_cause);
            end
        endfunction

        // Compares one accepted result with the oldest one due.
        function void match_result(out_item_t got);
            out_item_t want;
            if (due_results.size() == 0)
            begin
                report_failure("result with nothing due", '0, got);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.data !== want.data
                        || got.command !== want.command
                        || got.frame_length !== want.frame_length
                        || got.reject_cause !== want.reject_cause)
                    report_failure("result mismatch", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    ufrx_in_if  din();
    ufrx_out_if dout();

    uart_frame_receiver_xor_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .din      (din),
        .dout     (dout)
    );

    frame_scoreboard sb;
    in_item_t        rx_plan[$];
    int              noise_count;
    in_item_t        seen_item;
    out_item_t       seen_result;
    int              quiet_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Item and result monitor, with the no-progress watchdog.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            quiet_cycles++;
            if (din.valid && din.ready)
            begin
                seen_item.op      = din.op;
                seen_item.rx_byte = din.rx_byte;
                sb.track_rx_item(seen_item);
                quiet_cycles = 0;
            end
            if (dout.valid && dout.ready)
            begin
                seen_result.kind         = dout.kind;
                seen_result.data         = dout.data;
                seen_result.command      = dout.command;
                seen_result.frame_length = dout.frame_length;
                seen_result.reject_cause = dout.reject_cause;
                sb.match_result(seen_result);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result side stalls on a rotating mask that is redrawn every so often.
    initial
    begin
        logic [15:0] ready_mask;
        int          mask_pos;
        int          mask_left;
        dout.ready <= 1'b0;
        ready_mask = 16'hFFFF;
        mask_pos   = 0;
        mask_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (mask_left == 0)
            begin
                mask_left  = $urandom_range(32, 128);
                ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
            end
            mask_left--;
            dout.ready <= ready_mask[mask_pos];
            mask_pos = (mask_pos + 1) % 16;
        end
    end

    function automatic void add_item(op_t op, logic [7:0] b);
        in_item_t it;
        it.op      = op;
        it.rx_byte = b;
        rx_plan.push_back(it);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        add_item(OP_BYTE, b);
    endfunction

    function automatic void add_ticks(int n);
        repeat (n) add_item(OP_TICK, 8'($urandom));
    endfunction

    // Occasional ticks between frame bytes; with small limits they break frames.
    function automatic void maybe_ticks();
        if ($urandom_range(0, 5) == 0)
            add_ticks($urandom_range(1, 2));
    endfunction

    function automatic int tick_span(logic [15:0] limit);
        return (limit == 0) ? 1 : int'(limit);
    endfunction

    // Plans one frame, mostly well formed, with random content.
    function automatic void plan_frame();
        frame_plan_t fate;
        int          pick;
        int          lim_hdr;
        int          lim_pay;
        int          lim_chk;
        int          len_cap;
        int          n;
        int          first;
        int          cut;
        logic [15:0] len;
        logic [7:0]  cmd;
        logic [7:0]  chk;
        logic [7:0]  b;

        pick = $urandom_range(0, 99);
        if (pick < 45)      fate = PLAN_GOOD;
        else if (pick < 60) fate = PLAN_BAD_CHECK;
        else if (pick < 70) fate = PLAN_OVERSIZE;
        else if (pick < 78) fate = PLAN_PAYLOAD_STALL;
        else if (pick < 84) fate = PLAN_CHECK_STALL;
        else if (pick < 90) fate = PLAN_HEADER_STALL;
        else                fate = PLAN_TRUNCATED;

        lim_hdr = tick_span(sb.hdr_limit);
        lim_pay = tick_span(sb.pay_limit);
        lim_chk = tick_span(sb.chk_limit);

        // Fall back to a good frame where a case cannot arise or costs too much.
        if (fate == PLAN_OVERSIZE && sb.max_len == 16'hFFFF)
            fate = PLAN_GOOD;
        if (fate == PLAN_PAYLOAD_STALL && (lim_pay > TICK_CAP || sb.max_len == 0))
            fate = PLAN_GOOD;
        if (fate == PLAN_CHECK_STALL && lim_chk > TICK_CAP)
            fate = PLAN_GOOD;
        if (fate == PLAN_HEADER_STALL && lim_hdr > TICK_CAP)
            fate = PLAN_GOOD;
        if (fate == PLAN_TRUNCATED
                && (lim_hdr > TICK_CAP || lim_pay > TICK_CAP || lim_chk > TICK_CAP))
            fate = PLAN_GOOD;

        // Line noise while hunting, never a start byte.
        if ($urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                b = 8'($urandom);
                if (b == START_BYTE)
                    b = ~START_BYTE;
                add_item($urandom_range(0, 1) ? OP_TICK : OP_BYTE, b);
            end
            noise_count += n;
        end

        len_cap = (sb.max_len < 12) ? int'(sb.max_len) : 12;
        case (fate)
            PLAN_OVERSIZE:      len = 16'($urandom_range(int'(sb.max_len) + 1, 65535));
            PLAN_PAYLOAD_STALL: len = 16'($urandom_range(1, int'(sb.max_len)));
            default:            len = 16'($urandom_range(0, len_cap));
        endcase
        cmd = 8'($urandom);

        first = rx_plan.size();
        add_byte(START_BYTE);
        maybe_ticks();
        if (fate == PLAN_HEADER_STALL)
        begin
            if ($urandom_range(0, 1) == 1)
                add_byte(len[7:0]);
            add_ticks(lim_hdr);
            return;
        end
        add_byte(len[7:0]);
        maybe_ticks();
        add_byte(len[15:8]);
        maybe_ticks();
        add_byte(cmd);
        maybe_ticks();

        // An oversized frame ends on one more byte or on the check timeout.
        if (fate == PLAN_OVERSIZE)
        begin
            if ($urandom_range(0, 2) == 0 && lim_chk <= TICK_CAP)
                add_ticks(lim_chk);
            else
                add_byte(8'($urandom));
            return;
        end

        chk = cmd;
        if (fate == PLAN_PAYLOAD_STALL)
            n = $urandom_range(0, (len < 4) ? int'(len) - 1 : 3);
        else
            n = int'(len);
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            chk ^= b;
            add_byte(b);
            maybe_ticks();
        end

        case (fate)
            PLAN_PAYLOAD_STALL: add_ticks(lim_pay);
            PLAN_CHECK_STALL:   add_ticks(lim_chk);
            PLAN_BAD_CHECK:     add_byte(chk ^ 8'($urandom_range(1, 255)));
            default:            add_byte(chk);
        endcase

        // A broken frame stops short, then enough ticks return it to hunting.
        if (fate == PLAN_TRUNCATED)
        begin
            cut = $urandom_range(first + 1, rx_plan.size() - 1);
            while (rx_plan.size() > cut)
                void'(rx_plan.pop_back());
            add_ticks((lim_hdr > lim_pay) ? ((lim_hdr > lim_chk) ? lim_hdr : lim_chk)
                                          : ((lim_pay > lim_chk) ? lim_pay : lim_chk));
        end
    endfunction

    // Drives the planned items in bursts with random gaps between them.
    task automatic play_plan();
        int burst_left;
        burst_left = $urandom_range(1, 32);
        foreach (rx_plan[i])
        begin
            din.valid   <= 1'b1;
            din.op      <= rx_plan[i].op;
            din.rx_byte <= rx_plan[i].rx_byte;
            do @(posedge clk); while (din.ready !== 1'b1);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 32);
                if ($urandom_range(0, 3) != 0)
                begin
                    din.valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
        end
        din.valid <= 1'b0;
        rx_plan.delete();
    endtask

    // Waits until every due result has been taken and the output is empty.
    task automatic wait_idle();
        @(posedge clk);
        while (sb.due_results.size() != 0 || dout.valid !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] max_len, input logic [15:0] hdr,
                                  input logic [15:0] pay, input logic [15:0] chk);
        cfg_reg_t    idx[4];
        logic [15:0] val[4];
        idx = '{REG_MAX_LENGTH, REG_HEADER_TIMEOUT, REG_PAYLOAD_TIMEOUT, REG_CHECK_TIMEOUT};
        val = '{max_len, hdr, pay, chk};
        foreach (idx[i])
        begin
            wr_en    <= 1'b1;
            wr_index <= idx[i];
            wr_data  <= val[i];
            @(posedge clk);
            sb.set_register(idx[i], val[i]);
        end
        wr_en <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        sb           = new();
        quiet_cycles = 0;
        noise_count  = 0;
        rst_n       <= 1'b0;
        wr_en       <= 1'b0;
        wr_index    <= REG_MAX_LENGTH;
        wr_data     <= '0;
        din.valid   <= 1'b0;
        din.op      <= OP_BYTE;
        din.rx_byte <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset settings.
        add_item(OP_TICK, 8'hFF);
        add_byte(8'h00);
        // Good frame with two payload bytes
        add_byte(START_BYTE); add_byte(8'h02); add_byte(8'h00); add_byte(8'hA5);
        add_byte(8'h00); add_byte(8'hFF); add_byte(8'h5A);
        // Empty payload, check byte equal to the command
        add_byte(START_BYTE); add_byte(8'h00); add_byte(8'h00); add_byte(8'hFF);
        add_byte(8'hFF);
        // Check byte mismatch
        add_byte(START_BYTE); add_byte(8'h01); add_byte(8'h00); add_byte(8'h00);
        add_byte(8'h7E); add_byte(8'h00);
        // Largest length, rejected as too long on the next byte
        add_byte(START_BYTE); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'h3C);
        add_byte(8'h00);
        play_plan();
        wait_idle();

        // Random frames over a series of settings, extremes included.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: apply_settings(MAX_LENGTH_RST, HEADER_TIMEOUT_RST,
                                  PAYLOAD_TIMEOUT_RST, CHECK_TIMEOUT_RST);
                1: apply_settings(16'd0, 16'd1, 16'd1, 16'd1);
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
                4: apply_settings(16'($urandom_range(0, 20)), 16'($urandom_range(1, 8)),
                                  16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
                default: apply_settings(16'($urandom), 16'($urandom_range(1, 40)),
                                        16'($urandom_range(1, 40)),
                                        16'($urandom_range(1, 40)));
            endcase
            noise_count = 0;
            while (rx_plan.size() - noise_count < PHASE_ITEMS)
                plan_frame();
            play_plan();
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/ufrx_pkg.sv
rtl/core/ufrx_if.sv
rtl/core/uart_frame_receiver_xor_top.sv
bench/uart_frame_receiver_xor_top_tb.sv
